// ----- rtl/vfc_pkg.sv -----
// Shared types and constants for the voxel face culler.
// Used by vfc_ctrl, vfc_datapath and voxel_face_culler_core; no dependencies.

package vfc_pkg;

	localparam int COORD_W = 4;
	localparam int MASK_W  = 6;
	localparam int COORD_SPAN = 2 ** COORD_W;

	localparam int DEF_SIZE_X = 16;
	localparam int DEF_SIZE_Y = 16;
	localparam int DEF_SIZE_Z = 16;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// face mask bit positions
	localparam int FACE_PX = 0;
	localparam int FACE_NX = 1;
	localparam int FACE_PY = 2;
	localparam int FACE_NY = 3;
	localparam int FACE_PZ = 4;
	localparam int FACE_NZ = 5;

	// occupancy row copies, one read each per request
	localparam int NB_ROWS = 5;
	localparam int NB_CTR  = 0;
	localparam int NB_PX   = 1;
	localparam int NB_NX   = 2;
	localparam int NB_PY   = 3;
	localparam int NB_NY   = 4;

	typedef struct packed {
		logic               cmd;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [COORD_W-1:0] pos_z;
		logic               solid;
	} req_t;

	typedef struct packed {
		logic [COORD_W-1:0] out_x;
		logic [COORD_W-1:0] out_y;
		logic [COORD_W-1:0] out_z;
		logic [MASK_W-1:0]  face_mask;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_EVAL
	} state_t;

	typedef struct packed {
		logic load;
		logic eval;
	} ctrl_cmd_t;

endpackage

// ----- rtl/vfc_ram.sv -----
// Generic one-write, one-read RAM with registered read data.
// No dependencies.

module vfc_ram #(
	parameter int WIDTH  = 16,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/vfc_ctrl.sv -----
// Request sequencer for the voxel face culler: load, then evaluate.
// Depends on vfc_pkg.

module vfc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output vfc_pkg::ctrl_cmd_t  cmd
);

	vfc_pkg::state_t state_q;
	vfc_pkg::state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vfc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = vfc_pkg::ST_EVAL;
				end
			end
			vfc_pkg::ST_EVAL: begin
				state_d = vfc_pkg::ST_IDLE;
			end
			default: begin
				state_d = vfc_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load = 1'b0;
		cmd.eval = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			vfc_pkg::ST_IDLE: begin
				cmd.load = start;
			end
			vfc_pkg::ST_EVAL: begin
				cmd.eval = 1'b1;
				busy     = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/vfc_datapath.sv -----
// Occupancy storage and face evaluation: five row copies indexed by (x,y),
// each row holding the z column, plus per-row valid bits. Depends on vfc_pkg, vfc_ram.

module vfc_datapath #(
	parameter int SIZE_X = vfc_pkg::DEF_SIZE_X,
	parameter int SIZE_Y = vfc_pkg::DEF_SIZE_Y,
	parameter int SIZE_Z = vfc_pkg::DEF_SIZE_Z
) (
	input  logic               clk,
	input  logic               arst_n,
	input  vfc_pkg::ctrl_cmd_t cmd,
	input  vfc_pkg::req_t      req,
	output logic               valid,
	output vfc_pkg::rsp_t      rsp
);

	localparam int CW    = vfc_pkg::COORD_W;
	localparam int EXT_X = (SIZE_X < vfc_pkg::COORD_SPAN) ? SIZE_X : vfc_pkg::COORD_SPAN;
	localparam int EXT_Y = (SIZE_Y < vfc_pkg::COORD_SPAN) ? SIZE_Y : vfc_pkg::COORD_SPAN;
	localparam int EXT_Z = (SIZE_Z < vfc_pkg::COORD_SPAN) ? SIZE_Z : vfc_pkg::COORD_SPAN;
	localparam int ROWS  = EXT_X * EXT_Y;
	localparam int AW    = $clog2(ROWS);
	localparam int ZW    = $clog2(EXT_Z);
	localparam int MW    = 2 * CW + 2;

	function automatic logic [AW-1:0] row_addr(input logic [CW:0] x, input logic [CW:0] y);
		logic [MW-1:0] lin;
		lin = MW'(x) * MW'(EXT_Y) + MW'(y);
		return lin[AW-1:0];
	endfunction

	// neighbor coordinates at the input, one bit wider for the +1 carry
	logic [CW:0] x_c, y_c, x_p, y_p, x_m, y_m;
	logic        x_in, y_in, xp_in, yp_in, xm_in, ym_in;
	logic [AW-1:0] ctr_addr;
	logic [AW-1:0] rd_addr [vfc_pkg::NB_ROWS];

	always_comb begin
		x_c   = {1'b0, req.pos_x};
		y_c   = {1'b0, req.pos_y};
		x_p   = x_c + (CW+1)'(1);
		y_p   = y_c + (CW+1)'(1);
		x_m   = x_c - (CW+1)'(1);
		y_m   = y_c - (CW+1)'(1);
		x_in  = x_c < (CW+1)'(EXT_X);
		y_in  = y_c < (CW+1)'(EXT_Y);
		xp_in = x_p < (CW+1)'(EXT_X);
		yp_in = y_p < (CW+1)'(EXT_Y);
		xm_in = req.pos_x != '0;
		ym_in = req.pos_y != '0;
		// out-of-range addresses fall back to the center row; their data is masked
		ctr_addr = (x_in && y_in) ? row_addr(x_c, y_c) : '0;
		rd_addr[vfc_pkg::NB_CTR] = ctr_addr;
		rd_addr[vfc_pkg::NB_PX]  = (x_in && y_in && xp_in) ? row_addr(x_p, y_c) : ctr_addr;
		rd_addr[vfc_pkg::NB_NX]  = (x_in && y_in && xm_in) ? row_addr(x_m, y_c) : ctr_addr;
		rd_addr[vfc_pkg::NB_PY]  = (x_in && y_in && yp_in) ? row_addr(x_c, y_p) : ctr_addr;
		rd_addr[vfc_pkg::NB_NY]  = (x_in && y_in && ym_in) ? row_addr(x_c, y_m) : ctr_addr;
	end

	// request and per-row valid bits captured at load
	vfc_pkg::req_t               req_q;
	logic [AW-1:0]               addr_q;
	logic [vfc_pkg::NB_ROWS-1:0] nb_vld_q;
	logic [ROWS-1:0]             row_vld_q;

	logic [EXT_Z-1:0] rd_data [vfc_pkg::NB_ROWS];
	logic [EXT_Z-1:0] row     [vfc_pkg::NB_ROWS];
	logic [EXT_Z-1:0] new_row;
	logic             wr_en;

	genvar gi;
	generate
		for (gi = 0; gi < vfc_pkg::NB_ROWS; gi++) begin : g_copy
			vfc_ram #(
				.WIDTH  (EXT_Z),
				.DEPTH  (ROWS),
				.ADDR_W (AW)
			) u_ram (
				.clk   (clk),
				.we    (wr_en),
				.waddr (addr_q),
				.wdata (new_row),
				.re    (cmd.load),
				.raddr (rd_addr[gi]),
				.rdata (rd_data[gi])
			);
			// a row never written reads as all air
			assign row[gi] = nb_vld_q[gi] ? rd_data[gi] : '0;
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req;
			addr_q <= ctr_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_vld_q  <= '0;
			row_vld_q <= '0;
		end else begin
			if (cmd.load) begin
				for (int i = 0; i < vfc_pkg::NB_ROWS; i++) begin
					nb_vld_q[i] <= row_vld_q[rd_addr[i]];
				end
			end
			if (wr_en) begin
				row_vld_q[addr_q] <= 1'b1;
			end
		end
	end

	// evaluation on the captured request
	logic [CW:0]       qx, qy, qz, qz_p, qz_m;
	logic              q_in, qxp_in, qxm_in, qyp_in, qym_in, qzp_in, qzm_in;
	logic [ZW-1:0]     zi, zi_p, zi_m;
	logic              hit;
	logic [vfc_pkg::MASK_W-1:0] mask;

	always_comb begin
		qx     = {1'b0, req_q.pos_x};
		qy     = {1'b0, req_q.pos_y};
		qz     = {1'b0, req_q.pos_z};
		qz_p   = qz + (CW+1)'(1);
		qz_m   = qz - (CW+1)'(1);
		q_in   = (qx < (CW+1)'(EXT_X)) && (qy < (CW+1)'(EXT_Y)) && (qz < (CW+1)'(EXT_Z));
		qxp_in = (qx + (CW+1)'(1)) < (CW+1)'(EXT_X);
		qyp_in = (qy + (CW+1)'(1)) < (CW+1)'(EXT_Y);
		qzp_in = qz_p < (CW+1)'(EXT_Z);
		qxm_in = req_q.pos_x != '0;
		qym_in = req_q.pos_y != '0;
		qzm_in = req_q.pos_z != '0;
		zi     = qz[ZW-1:0];
		zi_p   = qz_p[ZW-1:0];
		zi_m   = qz_m[ZW-1:0];

		hit = q_in && row[vfc_pkg::NB_CTR][zi];

		mask = '0;
		mask[vfc_pkg::FACE_PX] = !(qxp_in && row[vfc_pkg::NB_PX][zi]);
		mask[vfc_pkg::FACE_NX] = !(qxm_in && row[vfc_pkg::NB_NX][zi]);
		mask[vfc_pkg::FACE_PY] = !(qyp_in && row[vfc_pkg::NB_PY][zi]);
		mask[vfc_pkg::FACE_NY] = !(qym_in && row[vfc_pkg::NB_NY][zi]);
		mask[vfc_pkg::FACE_PZ] = !(qzp_in && row[vfc_pkg::NB_CTR][zi_p]);
		mask[vfc_pkg::FACE_NZ] = !(qzm_in && row[vfc_pkg::NB_CTR][zi_m]);

		// read-modify-write of the center row; drop writes outside the chunk
		new_row     = row[vfc_pkg::NB_CTR];
		new_row[zi] = req_q.solid;
		wr_en       = cmd.eval && (req_q.cmd == vfc_pkg::CMD_WRITE) && q_in;
	end

	vfc_pkg::rsp_t rsp_q;
	logic          valid_q;

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			rsp_q.out_x     <= req_q.pos_x;
			rsp_q.out_y     <= req_q.pos_y;
			rsp_q.out_z     <= req_q.pos_z;
			rsp_q.face_mask <= mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.eval && (req_q.cmd == vfc_pkg::CMD_QUERY) && hit;
		end
	end

	assign valid = valid_q;
	assign rsp   = rsp_q;

endmodule

// ----- rtl/voxel_face_culler_core.sv -----
// Voxel face culler top level: occupancy bitmap with per-voxel face visibility.
// Depends on vfc_pkg, vfc_ctrl, vfc_datapath (which uses vfc_ram).
//
// Usage:
//   A request (req: cmd, pos_x, pos_y, pos_z, solid) is taken at a rising edge
//   where start is high and busy is low. cmd = write stores the solid bit of one
//   voxel; cmd = query looks up a voxel and, if it is solid and inside the chunk,
//   returns one result on rsp (coordinates and the six-bit visible-face mask,
//   +x,-x,+y,-y,+z,-z from bit 0) marked by valid for exactly one cycle.
//   Queries of air or out-of-chunk voxels, and all writes, return nothing.
// Timing:
//   The edge that takes a request also launches the reads of the center row
//   and its four (x,y) neighbor rows from five copies of the row memory; the
//   next cycle (busy high) evaluates the mask or writes the updated row back.
//   valid is high in the cycle after that, when the next request may already
//   be taken. No new request is taken while busy is high, as the registered
//   read of the row memories is followed by the row write-back.
// Reset:
//   arst_n clears the controller and the per-row valid bits, so the whole chunk
//   reads as air at once; no clearing pass is needed. Results cannot be held off.

module voxel_face_culler_core #(
	parameter int SIZE_X = vfc_pkg::DEF_SIZE_X,
	parameter int SIZE_Y = vfc_pkg::DEF_SIZE_Y,
	parameter int SIZE_Z = vfc_pkg::DEF_SIZE_Z
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  vfc_pkg::req_t req,
	output logic          busy,
	output logic          valid,
	output vfc_pkg::rsp_t rsp
);

	vfc_pkg::ctrl_cmd_t cmd;

	vfc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	vfc_datapath #(
		.SIZE_X (SIZE_X),
		.SIZE_Y (SIZE_Y),
		.SIZE_Z (SIZE_Z)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.valid  (valid),
		.rsp    (rsp)
	);

endmodule
